// ===== rtl/cmap_pkg.sv =====
// shared constants, coefficient table and breakpoint decode for the colormap
package cmap_pkg;

    localparam int VALUE_BITS   = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_MIN    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_MAX    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_CENTRE = 2'd2;

    localparam int RESET_MIN    = 0;
    localparam int RESET_MAX    = 80;
    localparam int RESET_CENTRE = 40;

    // position x is q1.24, one is 2^24
    localparam int XF = 24;
    localparam logic [XF:0] XONE  = (XF+1)'(1) << XF;
    localparam logic [XF:0] XHALF = (XF+1)'(1) << (XF - 1);

    // channel intensity in 1e-6 units
    localparam int UNIT      = 1000000;
    localparam int UNIT_BITS = 20;
    localparam int HALF_UNIT = 500000;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam int ROWS = 12;

    typedef logic signed [31:0] t_coef;
    typedef logic [3:0]         t_row;

    // rows: red 0..5, green 6..7, blue 8..11; columns a0..a3
    localparam t_coef COEF [ROWS][4] = '{
        '{0, 0, 0, 0},
        '{-1782709, 22937070, -86635448, 109222171},
        '{-765706, 3908358, -2385836, 911563},
        '{-18069920, 81220268, -115432390, 54731649},
        '{1000000, 0, 0, 0},
        '{688335, 804310, -553402, 51166},
        '{221600, 2096260, -2989336, 1865388},
        '{2304104, -4665514, 5405245, -2842239},
        '{964755, -3046139, 3252455, -6730486},
        '{34808, -485577, 2123163, -1570901},
        '{-692383, 4166389, -6037159, 2550446},
        '{0, 0, 0, 0}
    };

    function automatic t_coef coef(input t_row row, input logic [1:0] k);
        t_coef c;
        c = '0;
        if (row < t_row'(ROWS)) begin
            c = COEF[row][k];
        end
        return c;
    endfunction

    // exact test x < k/255
    function automatic logic below(input logic [XF:0] x, input int k);
        logic [33:0] x255;
        logic [33:0] lim;
        x255 = ({9'b0, x} << 8) - {9'b0, x};
        lim  = 34'(k) << XF;
        return x255 < lim;
    endfunction

    function automatic t_row seg_row(input logic [1:0] ch, input logic [XF:0] x);
        t_row r;
        r = '0;
        case (ch)
            CH_RED: begin
                if (below(x, 35))       r = 4'd0;
                else if (below(x, 79))  r = 4'd1;
                else if (below(x, 159)) r = 4'd2;
                else if (below(x, 189)) r = 4'd3;
                else if (below(x, 234)) r = 4'd4;
                else                    r = 4'd5;
            end
            CH_GREEN: begin
                r = below(x, 156) ? 4'd6 : 4'd7;
            end
            CH_BLUE: begin
                if (below(x, 88))       r = 4'd8;
                else if (below(x, 159)) r = 4'd9;
                else if (below(x, 246)) r = 4'd10;
                else                    r = 4'd11;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/cmap_norm.sv =====
// normalizes a sample to position x through a bit-per-stage divider pipeline
module cmap_norm #(
    parameter int VB = cmap_pkg::VALUE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [VB-1:0]        i_value,
    input  logic [VB-1:0]        i_min,
    input  logic [VB-1:0]        i_max,
    input  logic [VB-1:0]        i_centre,
    output logic                 o_valid,
    output logic [cmap_pkg::XF:0] o_x,
    output logic                 o_fault
);
    import cmap_pkg::*;

    localparam int QB = XF;

    logic                 lower;
    logic signed [VB:0]   num, den;
    logic [VB-1:0]        n_an, n_ad;
    logic                 n_neg, n_sat;

    always_comb begin
        lower = i_value < i_centre;
        if (lower) begin
            num = $signed({1'b0, i_value}) - $signed({1'b0, i_min});
            den = $signed({1'b0, i_centre}) - $signed({1'b0, i_min});
        end else begin
            num = $signed({1'b0, i_value}) - $signed({1'b0, i_centre});
            den = $signed({1'b0, i_max}) - $signed({1'b0, i_centre});
        end
        n_an  = num[VB] ? VB'(-num) : num[VB-1:0];
        n_ad  = den[VB] ? VB'(-den) : den[VB-1:0];
        n_neg = (num != '0) && (num[VB] != den[VB]);
        // ratio of two or more saturates x offset at one
        n_sat = {1'b0, n_an} >= {n_ad, 1'b0};
    end

    logic [VB-1:0] r_rem [QB+1];
    logic [VB-1:0] r_ad  [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_up  [QB+1];
    logic          r_flt [QB+1];
    logic          r_sat [QB+1];
    logic          r_v   [QB+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_an;
        r_ad[0]  <= n_ad;
        r_q[0]   <= '0;
        r_neg[0] <= n_neg;
        r_up[0]  <= !lower;
        r_flt[0] <= (den == '0);
        r_sat[0] <= n_sat;
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic [VB:0] rin;
        logic        qb;
        always_comb begin
            if (j == 1) rin = {1'b0, r_rem[j-1]};
            else        rin = {r_rem[j-1], 1'b0};
            qb = rin >= {1'b0, r_ad[j-1]};
        end
        always_ff @(posedge i_clk) begin
            r_rem[j] <= qb ? VB'(rin - {1'b0, r_ad[j-1]}) : rin[VB-1:0];
            r_ad[j]  <= r_ad[j-1];
            r_q[j]   <= {r_q[j-1][QB-2:0], qb};
            r_neg[j] <= r_neg[j-1];
            r_up[j]  <= r_up[j-1];
            r_flt[j] <= r_flt[j-1];
            r_sat[j] <= r_sat[j-1];
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    logic [XF:0]   t, base, n_x;
    logic [XF+1:0] sum;

    always_comb begin
        t    = r_sat[QB] ? XONE : {1'b0, r_q[QB]};
        base = r_up[QB] ? XHALF : '0;
        sum  = {1'b0, base} + {1'b0, t};
        if (r_flt[QB]) begin
            n_x = '0;
        end else if (r_neg[QB]) begin
            n_x = (t > base) ? '0 : base - t;
        end else begin
            n_x = (sum > {1'b0, XONE}) ? XONE : sum[XF:0];
        end
    end

    logic [XF:0] r_x;
    logic        r_fault, r_ov;

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_fault <= r_flt[QB];
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[QB];
        end
    end

    assign o_valid = r_ov;
    assign o_x     = r_x;
    assign o_fault = r_fault;

endmodule

// ===== rtl/cmap_chan.sv =====
// one color channel: segment pick, pipelined cubic, clamp and scale to channel bits
module cmap_chan #(
    parameter int         CB = cmap_pkg::CHANNEL_BITS,
    parameter logic [1:0] CH = cmap_pkg::CH_RED
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [cmap_pkg::XF:0] i_x,
    output logic                  o_valid,
    output logic [CB-1:0]         o_ch
);
    import cmap_pkg::*;

    localparam int PB = 2 * XF + 8;
    localparam int NW = UNIT_BITS + CB + 1;

    // one million is 2^6 * 15625: drop the low six bits, then multiply by a reciprocal
    localparam int DSH  = 6;
    localparam int DQ   = UNIT >> DSH;
    localparam int DLOG = 14;
    localparam int RB   = NW - DSH;
    localparam int MB   = RB + 1;
    localparam int RSH  = RB + DLOG;
    localparam int PW   = RB + MB;
    localparam logic [MB-1:0] RECIP = MB'(((64'd1 << RSH) + 64'(DQ) - 64'd1) / 64'(DQ));

    t_coef       r_p  [4];
    logic [XF:0] r_x  [4];
    t_row        r_sg [4];
    logic        r_vp [4];

    logic [PB-1:0] r_m_prod [3];
    logic          r_m_neg  [3];
    logic [XF:0]   r_m_x    [3];
    t_row          r_m_sg   [3];
    logic          r_m_v    [3];

    t_row n_row;
    assign n_row = seg_row(CH, i_x);

    always_ff @(posedge i_clk) begin
        r_x[0]  <= i_x;
        r_sg[0] <= n_row;
        r_p[0]  <= coef(n_row, 2'd3);
        if (!i_rst_n) begin
            r_vp[0] <= 1'b0;
        end else begin
            r_vp[0] <= i_valid;
        end
    end

    for (genvar h = 0; h < 3; h++) begin : g_horner
        logic [30:0]   pabs;
        logic [PB-1:0] rnd;
        logic [31:0]   mag;
        t_coef         m;

        assign pabs = r_p[h][31] ? 31'(-r_p[h]) : r_p[h][30:0];

        always_ff @(posedge i_clk) begin
            r_m_prod[h] <= PB'(pabs) * PB'(r_x[h]);
            r_m_neg[h]  <= r_p[h][31];
            r_m_x[h]    <= r_x[h];
            r_m_sg[h]   <= r_sg[h];
            if (!i_rst_n) begin
                r_m_v[h] <= 1'b0;
            end else begin
                r_m_v[h] <= r_vp[h];
            end
        end

        // negative products round toward minus infinity
        always_comb begin
            rnd = r_m_prod[h] + PB'(XONE - 1'b1);
            mag = r_m_neg[h] ? rnd[XF+31:XF] : r_m_prod[h][XF+31:XF];
            m   = r_m_neg[h] ? -$signed(mag) : $signed(mag);
        end

        always_ff @(posedge i_clk) begin
            r_p[h+1]  <= m + coef(r_m_sg[h], 2'(2 - h));
            r_x[h+1]  <= r_m_x[h];
            r_sg[h+1] <= r_m_sg[h];
            if (!i_rst_n) begin
                r_vp[h+1] <= 1'b0;
            end else begin
                r_vp[h+1] <= r_m_v[h];
            end
        end
    end

    logic [UNIT_BITS-1:0] pc;
    always_comb begin
        if (r_p[3] < 0)                pc = '0;
        else if (r_p[3] > t_coef'(UNIT)) pc = UNIT_BITS'(UNIT);
        else                           pc = r_p[3][UNIT_BITS-1:0];
    end

    logic [NW-1:0] r_n;
    logic          r_nv;
    logic [PW-1:0] r_prod;
    logic          r_pv;

    // scaled value rounded half up, then divided by one million
    always_ff @(posedge i_clk) begin
        r_n    <= (NW'(pc) << CB) - NW'(pc) + NW'(HALF_UNIT);
        r_prod <= PW'(r_n[NW-1:DSH]) * PW'(RECIP);
        if (!i_rst_n) begin
            r_nv <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_nv <= r_vp[3];
            r_pv <= r_nv;
        end
    end

    assign o_valid = r_pv;
    assign o_ch    = r_prod[RSH+CB-1:RSH];

endmodule

// ===== rtl/value_to_rgb_colormap.sv =====
// top level of the scalar to rgb colormap pipeline
// A sample is taken at every clock edge where start is high; busy is always low, so one
// sample per clock is sustained. Each sample gives one color on o_red/o_green/o_blue with
// o_range_fault, marked by a one-cycle o_valid strobe. The path runs through normalization
// (registered front end, the 24-stage divider and the offset and clamp stage), the segment
// pick and the three multiply/add pairs of the cubic, and the reciprocal scaling to channel
// bits; its depth does not depend on CHANNEL_BITS. The receiver cannot stall the strobe, so
// results must be captured when o_valid is high. Range registers are written through the
// cfg channel, which is always ready; write them only while no transaction is in flight.
module value_to_rgb_colormap #(
    parameter int VALUE_BITS   = cmap_pkg::VALUE_BITS,
    parameter int CHANNEL_BITS = cmap_pkg::CHANNEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              start,
    output logic                              busy,
    input  logic [VALUE_BITS-1:0]             i_sample_value,
    // result strobe
    output logic                              o_valid,
    output logic [CHANNEL_BITS-1:0]           o_red,
    output logic [CHANNEL_BITS-1:0]           o_green,
    output logic [CHANNEL_BITS-1:0]           o_blue,
    output logic                              o_range_fault,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cmap_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [VALUE_BITS-1:0]             i_cfg_data
);
    import cmap_pkg::*;

    // fault bit rides beside the channel pipelines for their whole depth
    localparam int CHAN_LAT = 9;

    logic [VALUE_BITS-1:0] r_range_min, r_range_max, r_range_centre;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // range registers; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min    <= VALUE_BITS'(RESET_MIN);
            r_range_max    <= VALUE_BITS'(RESET_MAX);
            r_range_centre <= VALUE_BITS'(RESET_CENTRE);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RANGE_MIN:    r_range_min    <= i_cfg_data;
                REG_RANGE_MAX:    r_range_max    <= i_cfg_data;
                REG_RANGE_CENTRE: r_range_centre <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic        nx_valid, nx_fault;
    logic [XF:0] nx_x;

    // normalize to position x in [0,1], q1.24
    cmap_norm #(.VB(VALUE_BITS)) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_value  (i_sample_value),
        .i_min    (r_range_min),
        .i_max    (r_range_max),
        .i_centre (r_range_centre),
        .o_valid  (nx_valid),
        .o_x      (nx_x),
        .o_fault  (nx_fault)
    );

    logic red_v, green_v, blue_v;

    cmap_chan #(.CB(CHANNEL_BITS), .CH(CH_RED)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nx_valid),
        .i_x     (nx_x),
        .o_valid (red_v),
        .o_ch    (o_red)
    );

    cmap_chan #(.CB(CHANNEL_BITS), .CH(CH_GREEN)) u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nx_valid),
        .i_x     (nx_x),
        .o_valid (green_v),
        .o_ch    (o_green)
    );

    cmap_chan #(.CB(CHANNEL_BITS), .CH(CH_BLUE)) u_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nx_valid),
        .i_x     (nx_x),
        .o_valid (blue_v),
        .o_ch    (o_blue)
    );

    // fault delay line matched to the channel latency
    logic r_flt [CHAN_LAT];
    always_ff @(posedge i_clk) begin
        r_flt[0] <= nx_fault;
        for (int i = 1; i < CHAN_LAT; i++) begin
            r_flt[i] <= r_flt[i-1];
        end
    end

    // all three channels run in lockstep
    assign o_valid       = red_v && green_v && blue_v;
    assign o_range_fault = r_flt[CHAN_LAT-1];

endmodule
